@@ rtl/ddps_pkg.sv @@
// Package for the differential drive PI speed unit.
// Fixed-point constants, register indexes, sequencer codes and control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ddps_pkg;

    // Fixed-point format: signed, FRAC_BITS fraction bits
    localparam int FRAC_BITS = 8;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    // Gains and limits, rounded to nearest
    localparam int K_HEAD   = ((35 << FRAC_BITS) + 50) / 100;
    localparam int KP_L     = ((25 << FRAC_BITS) + 50) / 100;
    localparam int KI_L     = ((120 << FRAC_BITS) + 50) / 100;
    localparam int KP_R     = ((18 << FRAC_BITS) + 50) / 100;
    localparam int KI_R     = ((90 << FRAC_BITS) + 50) / 100;
    localparam int ALPHA    = ((22 << FRAC_BITS) + 50) / 100;
    localparam int VTRIM_R  = ((90 << FRAC_BITS) + 50) / 100;
    localparam int HEAD_MAX = 120 * ONE_Q;
    localparam int INT_LIM  = 300 * ONE_Q;

    localparam int SPEED_SHIFT = 3 + FRAC_BITS;  // base * 8 in QF
    localparam int BASE_SLEW   = 6;
    localparam int PWM_MIN     = 40;
    localparam int CAP_MARGIN  = 10;
    localparam int PWM_MAX     = 255;

    // Shared multiplier widths
    localparam int MA_W = 35;
    localparam int MB_W = 17;
    localparam int MP_W = MA_W + MB_W;

    // Configuration register indexes
    localparam logic [1:0] REG_PERIOD     = 2'd0;
    localparam logic [1:0] REG_RATE       = 2'd1;
    localparam logic [1:0] REG_TRIM_LEFT  = 2'd2;
    localparam logic [1:0] REG_TRIM_RIGHT = 2'd3;

    // One entry per multiply of a control tick
    typedef enum logic [3:0] {
        OP_SPD_L,
        OP_FLT_L,
        OP_SPD_R,
        OP_FLT_R,
        OP_HEAD,
        OP_VTR,
        OP_INT_L,
        OP_P_L,
        OP_I_L,
        OP_INT_R,
        OP_P_R,
        OP_I_R
    } ddps_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_DONE
    } ddps_state_t;

    typedef struct packed {
        logic     load;      // latch input beat
        logic     wb;        // write back product of op
        logic     out_load;  // move duties to output register
        ddps_op_t op;
    } ddps_cmd_t;

    typedef struct packed {
        logic restart;       // latched beat was a restart
    } ddps_stat_t;

endpackage

`default_nettype wire

@@ rtl/ddps_in_if.sv @@
// Input channel of the differential drive PI speed unit.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none

interface ddps_in_if;
    logic               valid;
    logic               ready;
    logic               restart;
    logic signed [23:0] heading_error;
    logic signed [15:0] delta_left;
    logic signed [15:0] delta_right;
    logic        [7:0]  target_pwm;

    modport source (output valid, restart, heading_error, delta_left, delta_right,
                    target_pwm, input ready);
    modport sink (input valid, restart, heading_error, delta_left, delta_right,
                  target_pwm, output ready);
endinterface

`default_nettype wire

@@ rtl/ddps_out_if.sv @@
// Output channel of the differential drive PI speed unit.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none

interface ddps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pwm_left;
    logic [7:0] pwm_right;

    modport source (output valid, pwm_left, pwm_right, input ready);
    modport sink (input valid, pwm_left, pwm_right, output ready);
endinterface

`default_nettype wire

@@ rtl/ddps_ctrl.sv @@
// Sequencer of the speed unit: walks the multiply list and owns the handshakes.
// Depends on ddps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddps_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire ddps_pkg::ddps_stat_t stat,
    output ddps_pkg::ddps_cmd_t       cmd
);

    ddps_pkg::ddps_state_t state_reg, state_next;
    ddps_pkg::ddps_op_t    op_reg, op_next;
    logic                  valid_reg, valid_next;
    logic                  slot_free;

    assign slot_free = !valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ddps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ddps_pkg::ST_MUL;
                    op_next    = ddps_pkg::OP_SPD_L;
                end
            end
            ddps_pkg::ST_MUL:
            begin
                // restart skips all arithmetic
                if (stat.restart)
                    state_next = ddps_pkg::ST_DONE;
                else
                    state_next = ddps_pkg::ST_WB;
            end
            ddps_pkg::ST_WB:
            begin
                if (op_reg == ddps_pkg::OP_I_R)
                    state_next = ddps_pkg::ST_DONE;
                else
                begin
                    state_next = ddps_pkg::ST_MUL;
                    op_next    = ddps_pkg::ddps_op_t'(op_reg + 4'd1);
                end
            end
            ddps_pkg::ST_DONE:
            begin
                if (slot_free)
                    state_next = ddps_pkg::ST_IDLE;
            end
            default: state_next = ddps_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.load     = 1'b0;
        cmd.wb       = 1'b0;
        cmd.out_load = 1'b0;
        cmd.op       = op_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            ddps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ddps_pkg::ST_MUL: ;
            ddps_pkg::ST_WB:   cmd.wb = 1'b1;
            ddps_pkg::ST_DONE: cmd.out_load = slot_free;
            default: ;
        endcase
    end

    // Output valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (cmd.out_load)
            valid_next = 1'b1;
    end

    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddps_pkg::ST_IDLE;
            op_reg    <= ddps_pkg::OP_SPD_L;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ddps_dp.sv @@
// Datapath of the speed unit: shared multiplier, controller state and config.
// Depends on ddps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddps_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [1:0]          wr_addr,
    input  wire logic [15:0]         wr_data,
    input  wire logic                in_restart,
    input  wire logic signed [23:0]  in_heading,
    input  wire logic signed [15:0]  in_dl,
    input  wire logic signed [15:0]  in_dr,
    input  wire logic [7:0]          in_target,
    input  wire ddps_pkg::ddps_cmd_t cmd,
    output ddps_pkg::ddps_stat_t     stat,
    output logic [7:0]               pwm_left,
    output logic [7:0]               pwm_right
);

    localparam int MP_W = ddps_pkg::MP_W;
    localparam int MA_W = ddps_pkg::MA_W;
    localparam int MB_W = ddps_pkg::MB_W;

    // Configuration
    logic [15:0]        period_reg, rate_reg;
    logic signed [8:0]  trim_l_reg, trim_r_reg;

    // Beat and loop state
    logic               restart_reg;
    logic signed [23:0] head_reg;
    logic signed [15:0] dl_reg, dr_reg;
    logic [7:0]         target_reg, ramp_reg, ramp_next;
    logic signed [31:0] vf_l_reg, vf_r_reg;
    logic signed [23:0] integ_l_reg, integ_r_reg;

    // Scratch
    logic signed [33:0] diff_reg;
    logic signed [16:0] corr_reg;
    logic signed [21:0] vref_r_reg;
    logic signed [32:0] e_l_reg, e_r_reg;
    logic signed [47:0] acc_reg;
    logic [7:0]         duty_l_reg, duty_r_reg, out_l_reg, out_r_reg;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod_reg, rnd8, rnd16;
    logic signed [21:0]     vbase;
    logic signed [31:0]     vf_sel;
    logic signed [35:0]     filt_sum;
    logic signed [31:0]     filt_sat;
    logic signed [23:0]     integ_sel;
    logic signed [36:0]     integ_sum;
    logic signed [23:0]     integ_sat;
    logic signed [16:0]     corr_sat;
    logic signed [47:0]     acc_base, acc_fin;
    logic [8:0]             cap;
    logic [7:0]             duty_fin;

    // Truncate toward zero, clamp to [0, cap], lift small duties to the floor
    function automatic logic [7:0] duty_of(input logic signed [47:0] s,
                                           input logic [8:0] c);
        logic signed [31:0] p;
        logic [8:0]         r;
        p = 32'(s >>> (2 * ddps_pkg::FRAC_BITS));
        if (s < 0)
            r = 9'd0;
        else if (p > $signed({23'd0, c}))
            r = c;
        else
            r = p[8:0];
        if (r != 9'd0 && r < 9'(ddps_pkg::PWM_MIN))
            r = 9'(ddps_pkg::PWM_MIN);
        return r[7:0];
    endfunction

    assign stat.restart = restart_reg;
    assign pwm_left     = out_l_reg;
    assign pwm_right    = out_r_reg;

    // Ramp toward target, at most one step per tick
    always_comb
    begin
        ramp_next = ramp_reg;
        if (in_target > ramp_reg)
            ramp_next = (in_target - ramp_reg > 8'(ddps_pkg::BASE_SLEW)) ?
                        ramp_reg + 8'(ddps_pkg::BASE_SLEW) : in_target;
        else if (in_target < ramp_reg)
            ramp_next = (ramp_reg - in_target > 8'(ddps_pkg::BASE_SLEW)) ?
                        ramp_reg - 8'(ddps_pkg::BASE_SLEW) : in_target;
    end

    assign vbase = 22'(ramp_reg) <<< ddps_pkg::SPEED_SHIFT;

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            ddps_pkg::OP_SPD_L:
            begin
                mul_a = MA_W'(dl_reg);
                mul_b = $signed({1'b0, rate_reg});
            end
            ddps_pkg::OP_SPD_R:
            begin
                mul_a = MA_W'(dr_reg);
                mul_b = $signed({1'b0, rate_reg});
            end
            ddps_pkg::OP_FLT_L, ddps_pkg::OP_FLT_R:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = MB_W'(ddps_pkg::ALPHA);
            end
            ddps_pkg::OP_HEAD:
            begin
                mul_a = MA_W'(head_reg);
                mul_b = MB_W'(ddps_pkg::K_HEAD);
            end
            ddps_pkg::OP_VTR:
            begin
                mul_a = MA_W'(vbase) + MA_W'(corr_reg);
                mul_b = MB_W'(ddps_pkg::VTRIM_R);
            end
            ddps_pkg::OP_INT_L:
            begin
                mul_a = MA_W'(e_l_reg);
                mul_b = $signed({1'b0, period_reg});
            end
            ddps_pkg::OP_P_L:
            begin
                mul_a = MA_W'(e_l_reg);
                mul_b = MB_W'(ddps_pkg::KP_L);
            end
            ddps_pkg::OP_I_L:
            begin
                mul_a = MA_W'(integ_l_reg);
                mul_b = MB_W'(ddps_pkg::KI_L);
            end
            ddps_pkg::OP_INT_R:
            begin
                mul_a = MA_W'(e_r_reg);
                mul_b = $signed({1'b0, period_reg});
            end
            ddps_pkg::OP_P_R:
            begin
                mul_a = MA_W'(e_r_reg);
                mul_b = MB_W'(ddps_pkg::KP_R);
            end
            ddps_pkg::OP_I_R:
            begin
                mul_a = MA_W'(integ_r_reg);
                mul_b = MB_W'(ddps_pkg::KI_R);
            end
            default: ;
        endcase
    end

    // Product rounding, ties toward plus infinity
    assign rnd8  = (prod_reg + (MP_W'(1) <<< (ddps_pkg::FRAC_BITS - 1)))
                   >>> ddps_pkg::FRAC_BITS;
    assign rnd16 = (prod_reg + (MP_W'(1) <<< 15)) >>> 16;

    // Low-pass update with 32-bit saturation
    assign vf_sel   = (cmd.op == ddps_pkg::OP_FLT_R || cmd.op == ddps_pkg::OP_SPD_R) ?
                      vf_r_reg : vf_l_reg;
    assign filt_sum = 36'(vf_sel) + 36'(rnd8);
    always_comb
    begin
        if (filt_sum > 36'sh0_7FFF_FFFF)
            filt_sat = 32'sh7FFF_FFFF;
        else if (filt_sum < -36'sh0_8000_0000)
            filt_sat = 32'sh8000_0000;
        else
            filt_sat = filt_sum[31:0];
    end

    // Integrator update with clamp
    assign integ_sel = (cmd.op == ddps_pkg::OP_INT_R) ? integ_r_reg : integ_l_reg;
    assign integ_sum = 37'(integ_sel) + 37'(rnd16);
    always_comb
    begin
        if (integ_sum > 37'(ddps_pkg::INT_LIM))
            integ_sat = 24'(ddps_pkg::INT_LIM);
        else if (integ_sum < -37'(ddps_pkg::INT_LIM))
            integ_sat = -24'(ddps_pkg::INT_LIM);
        else
            integ_sat = integ_sum[23:0];
    end

    // Heading correction clamp
    always_comb
    begin
        if (prod_reg > MP_W'(ddps_pkg::HEAD_MAX))
            corr_sat = 17'(ddps_pkg::HEAD_MAX);
        else if (prod_reg < -MP_W'(ddps_pkg::HEAD_MAX))
            corr_sat = -17'(ddps_pkg::HEAD_MAX);
        else
            corr_sat = prod_reg[16:0];
    end

    // Duty sum: (base + trim) in double-fraction format plus P term
    always_comb
    begin
        if (cmd.op == ddps_pkg::OP_P_R)
            acc_base = 48'($signed({2'b00, ramp_reg}) + 10'(trim_r_reg));
        else
            acc_base = 48'($signed({2'b00, ramp_reg}) + 10'(trim_l_reg));
    end
    assign acc_fin  = acc_reg + 48'(prod_reg);
    assign cap      = (9'(target_reg) + 9'(ddps_pkg::CAP_MARGIN) > 9'(ddps_pkg::PWM_MAX)) ?
                      9'(ddps_pkg::PWM_MAX) : 9'(target_reg) + 9'(ddps_pkg::CAP_MARGIN);
    assign duty_fin = duty_of(acc_fin, cap);

    // Shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= MP_W'(mul_a) * MP_W'(mul_b);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 16'd655;
            rate_reg   <= 16'd25600;
            trim_l_reg <= '0;
            trim_r_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_addr)
                ddps_pkg::REG_PERIOD:     period_reg <= wr_data;
                ddps_pkg::REG_RATE:       rate_reg   <= wr_data;
                ddps_pkg::REG_TRIM_LEFT:  trim_l_reg <= wr_data[8:0];
                ddps_pkg::REG_TRIM_RIGHT: trim_r_reg <= wr_data[8:0];
                default: ;
            endcase
        end
    end

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg    <= '0;
            vf_l_reg    <= '0;
            vf_r_reg    <= '0;
            integ_l_reg <= '0;
            integ_r_reg <= '0;
            restart_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            restart_reg <= in_restart;
            if (in_restart)
            begin
                ramp_reg    <= '0;
                vf_l_reg    <= '0;
                vf_r_reg    <= '0;
                integ_l_reg <= '0;
                integ_r_reg <= '0;
            end
            else
                ramp_reg <= ramp_next;
        end
        else if (cmd.wb)
        begin
            case (cmd.op)
                ddps_pkg::OP_FLT_L: vf_l_reg    <= filt_sat;
                ddps_pkg::OP_FLT_R: vf_r_reg    <= filt_sat;
                ddps_pkg::OP_INT_L: integ_l_reg <= integ_sat;
                ddps_pkg::OP_INT_R: integ_r_reg <= integ_sat;
                default: ;
            endcase
        end
    end

    // Beat capture and scratch registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            head_reg   <= in_heading;
            dl_reg     <= in_dl;
            dr_reg     <= in_dr;
            target_reg <= in_target;
            duty_l_reg <= '0;
            duty_r_reg <= '0;
        end
        else if (cmd.wb)
        begin
            case (cmd.op)
                ddps_pkg::OP_SPD_L, ddps_pkg::OP_SPD_R:
                    diff_reg <= 34'(prod_reg) - 34'(vf_sel);
                ddps_pkg::OP_HEAD:
                    corr_reg <= corr_sat;
                ddps_pkg::OP_VTR:
                begin
                    vref_r_reg <= rnd8[21:0];
                    e_l_reg    <= 33'(vbase) - 33'(corr_reg) - 33'(vf_l_reg);
                end
                ddps_pkg::OP_INT_L:
                    e_r_reg <= 33'(vref_r_reg) - 33'(vf_r_reg);
                ddps_pkg::OP_P_L, ddps_pkg::OP_P_R:
                    acc_reg <= (acc_base <<< (2 * ddps_pkg::FRAC_BITS)) + 48'(prod_reg);
                ddps_pkg::OP_I_L:
                    duty_l_reg <= duty_fin;
                ddps_pkg::OP_I_R:
                    duty_r_reg <= duty_fin;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_l_reg <= duty_l_reg;
            out_r_reg <= duty_r_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/differential_drive_pi_speed_unit.sv @@
// Top level of the differential drive PI speed unit.
// Depends on ddps_pkg, ddps_in_if, ddps_out_if, ddps_ctrl and ddps_dp.
`timescale 1ns / 1ps
`default_nettype none

// One beat on sample is one control tick: the unit ramps its base duty, filters
// both wheel speeds, forms the heading correction and runs a PI loop per wheel,
// then offers both duties on duty. All products go through one registered
// multiplier in twelve steps, each a multiply state then a write-back state;
// a restart beat skips the arithmetic. A new beat is taken as soon as the
// previous one has moved to the output register, so a result waiting on duty
// does not block the next computation. Register writes (period, rate, left
// and right trim) are to be made while idle.
module differential_drive_pi_speed_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire logic [1:0]  wr_addr,
    input  wire logic [15:0] wr_data,
    ddps_in_if.sink    sample,
    ddps_out_if.source duty
);

    ddps_pkg::ddps_cmd_t  cmd;
    ddps_pkg::ddps_stat_t stat;

    ddps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (duty.valid),
        .out_ready (duty.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ddps_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .in_restart (sample.restart),
        .in_heading (sample.heading_error),
        .in_dl      (sample.delta_left),
        .in_dr      (sample.delta_right),
        .in_target  (sample.target_pwm),
        .cmd        (cmd),
        .stat       (stat),
        .pwm_left   (duty.pwm_left),
        .pwm_right  (duty.pwm_right)
    );

    // Only one tick in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("beat accepted while a tick is in flight");

    // Duties are zero or at least the floor
    a_floor_left: assert property (@(posedge clk) disable iff (!rst_n)
        duty.valid && duty.pwm_left != 8'd0 |-> duty.pwm_left >= 8'(ddps_pkg::PWM_MIN))
        else $error("left duty below floor");

    a_floor_right: assert property (@(posedge clk) disable iff (!rst_n)
        duty.valid && duty.pwm_right != 8'd0 |-> duty.pwm_right >= 8'(ddps_pkg::PWM_MIN))
        else $error("right duty below floor");

endmodule

`default_nettype wire
